### rtl/assert_macros.svh
// Assertion macros for the ray sphere intersection checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every clock edge outside reset
`define RSI_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("ray sphere intersect check failed");

// check a property on every clock edge, reset included
`define RSI_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("ray sphere intersect reset check failed");

`endif

### rtl/rsi_pkg.sv
// Shared types and constants of the ray sphere intersection pipeline.
package rsi_pkg;

   localparam int MIN_DISTANCE = 66;

   localparam int HB_W      = 37;
   localparam int SQ_W      = 72;
   localparam int SQ_STEPS  = 36;
   localparam int ROOT_W    = SQ_STEPS;
   localparam int T_W       = 39;
   localparam int DIV_STEPS = 32;

   localparam logic [31:0] Q_TWO = 32'h8000_0000;
   localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;

   typedef enum logic [1:0] {
      CSR_CENTER_X = 2'd0,
      CSR_CENTER_Y = 2'd1,
      CSR_CENTER_Z = 2'd2,
      CSR_RADIUS   = 2'd3
   } csr_index_type;

   typedef logic signed [31:0] s32_type;

   typedef struct packed {
      s32_type     origin_x;
      s32_type     origin_y;
      s32_type     origin_z;
      s32_type     dir_x;
      s32_type     dir_y;
      s32_type     dir_z;
      logic [30:0] max_distance;
   } req_type;

   typedef struct packed {
      logic        hit_found;
      logic [30:0] hit_distance;
      s32_type     point_x;
      s32_type     point_y;
      s32_type     point_z;
      s32_type     normal_x;
      s32_type     normal_y;
      s32_type     normal_z;
   } rsp_type;

   typedef struct packed {
      s32_type [2:0]          org;
      s32_type [2:0]          dir;
      logic signed [HB_W-1:0] hb;
      logic [30:0]            tmax;
      logic                   miss;
   } sq_pay_type;

   typedef struct packed {
      logic          hit;
      logic [30:0]   t;
      s32_type [2:0] point;
      logic [2:0]    neg;
      logic [2:0]    big;
   } div_pay_type;

endpackage

### rtl/rsi_front.sv
// Front stages: offset, dot products, squares and discriminant.
module rsi_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  rsi_pkg::req_type          in_req,
   input  rsi_pkg::s32_type [2:0]    center,
   input  logic [30:0]               radius,
   output logic                      out_valid,
   output logic [rsi_pkg::SQ_W-1:0]  out_op,
   output rsi_pkg::sq_pay_type       out_pay
);
   import rsi_pkg::*;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   sq_pay_type pay1_in, pay1_ff, pay2_ff, pay3_in, pay3_ff, pay4_ff, pay5_in, pay5_ff;

   logic signed [32:0] p1_in [3];
   logic signed [32:0] p1_ff [3];
   logic [32:0]        pmag [3];
   logic signed [64:0] prod2_in [3];
   logic signed [64:0] prod2_ff [3];
   logic [65:0]        psq2_in [3];
   logic [65:0]        psq2_ff [3];
   logic [61:0]        rsq2_in, rsq2_ff, rsq3_ff;
   logic [67:0]        psum3_in, psum3_ff;
   logic [HB_W-1:0]    hmag;
   logic [35:0]        hh4_in, hh4_ff, hl4_in, hl4_ff, ll4_in, ll4_ff;
   logic signed [68:0] rmp4_in, rmp4_ff;
   logic [SQ_W-1:0]    hbsq;
   logic signed [72:0] disc;
   logic [SQ_W-1:0]    op5_in, op5_ff;

   always_comb begin
      pay1_in      = '0;
      pay1_in.org  = {in_req.origin_z, in_req.origin_y, in_req.origin_x};
      pay1_in.dir  = {in_req.dir_z, in_req.dir_y, in_req.dir_x};
      pay1_in.tmax = in_req.max_distance;
      for (int i = 0; i < 3; i++) begin
         p1_in[i] = $signed({pay1_in.org[i][31], pay1_in.org[i]})
                  - $signed({center[i][31], center[i]});
      end

      for (int i = 0; i < 3; i++) begin
         prod2_in[i] = p1_ff[i] * $signed(pay1_ff.dir[i]);
         pmag[i]     = p1_ff[i][32] ? 33'(-p1_ff[i]) : 33'(p1_ff[i]);
         psq2_in[i]  = 66'(pmag[i]) * 66'(pmag[i]);
      end
      rsq2_in = 62'(radius) * 62'(radius);

      pay3_in    = pay2_ff;
      pay3_in.hb = $signed(prod2_ff[0][64:30]) + $signed(prod2_ff[1][64:30])
                 + $signed(prod2_ff[2][64:30]);
      psum3_in   = 68'(psq2_ff[0]) + 68'(psq2_ff[1]) + 68'(psq2_ff[2]);

      hmag    = pay3_ff.hb[HB_W-1] ? HB_W'(-pay3_ff.hb) : HB_W'(pay3_ff.hb);
      hh4_in  = hmag[35:18] * hmag[35:18];
      hl4_in  = hmag[35:18] * hmag[17:0];
      ll4_in  = hmag[17:0] * hmag[17:0];
      rmp4_in = $signed({7'b0, rsq3_ff}) - $signed({1'b0, psum3_ff});

      hbsq         = (SQ_W'(hh4_ff) << 36) + (SQ_W'(hl4_ff) << 19) + SQ_W'(ll4_ff);
      disc         = $signed({1'b0, hbsq}) + rmp4_ff;
      pay5_in      = pay4_ff;
      pay5_in.miss = disc[72];
      op5_in       = disc[72] ? '0 : disc[SQ_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
      if (en) begin
         pay1_ff  <= pay1_in;
         p1_ff    <= p1_in;
         pay2_ff  <= pay1_ff;
         prod2_ff <= prod2_in;
         psq2_ff  <= psq2_in;
         rsq2_ff  <= rsq2_in;
         pay3_ff  <= pay3_in;
         psum3_ff <= psum3_in;
         rsq3_ff  <= rsq2_ff;
         pay4_ff  <= pay3_ff;
         hh4_ff   <= hh4_in;
         hl4_ff   <= hl4_in;
         ll4_ff   <= ll4_in;
         rmp4_ff  <= rmp4_in;
         pay5_ff  <= pay5_in;
         op5_ff   <= op5_in;
      end
   end

   assign out_valid = v5_ff;
   assign out_op    = op5_ff;
   assign out_pay   = pay5_ff;

endmodule

### rtl/rsi_sqrt.sv
// Square root pipeline: one root bit per stage.
module rsi_sqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [rsi_pkg::SQ_W-1:0]    in_op,
   input  rsi_pkg::sq_pay_type         in_pay,
   output logic                        out_valid,
   output logic [rsi_pkg::ROOT_W-1:0]  out_root,
   output rsi_pkg::sq_pay_type         out_pay
);
   import rsi_pkg::*;

   logic            v_ff   [SQ_STEPS];
   logic [SQ_W-1:0] op_ff  [SQ_STEPS];
   logic [SQ_W-1:0] res_ff [SQ_STEPS];
   sq_pay_type      pay_ff [SQ_STEPS];

   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
      localparam logic [SQ_W-1:0] ONE = SQ_W'(1) << (2 * (SQ_STEPS - 1 - k));
      logic            v_prev;
      logic [SQ_W-1:0] op_prev, res_prev, trial, op_in, res_in;
      sq_pay_type      pay_prev;

      if (k == 0) begin : g_first
         assign v_prev   = in_valid;
         assign op_prev  = in_op;
         assign res_prev = '0;
         assign pay_prev = in_pay;
      end else begin : g_next
         assign v_prev   = v_ff[k-1];
         assign op_prev  = op_ff[k-1];
         assign res_prev = res_ff[k-1];
         assign pay_prev = pay_ff[k-1];
      end

      always_comb begin
         trial = res_prev + ONE;
         if (op_prev >= trial) begin
            op_in  = op_prev - trial;
            res_in = (res_prev >> 1) + ONE;
         end else begin
            op_in  = op_prev;
            res_in = res_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_prev;
         end
         if (en) begin
            op_ff[k]  <= op_in;
            res_ff[k] <= res_in;
            pay_ff[k] <= pay_prev;
         end
      end
   end

   assign out_valid = v_ff[SQ_STEPS-1];
   assign out_root  = res_ff[SQ_STEPS-1][ROOT_W-1:0];
   assign out_pay   = pay_ff[SQ_STEPS-1];

endmodule

### rtl/rsi_tail.sv
// Root selection, hit test, hit point and offset from the center.
module rsi_tail (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [rsi_pkg::ROOT_W-1:0]  in_root,
   input  rsi_pkg::sq_pay_type         in_pay,
   input  rsi_pkg::s32_type [2:0]      center,
   input  logic [30:0]                 radius,
   output logic                        out_valid,
   output rsi_pkg::div_pay_type        out_pay,
   output logic [2:0][31:0]            out_mag
);
   import rsi_pkg::*;

   localparam logic signed [T_W-1:0] MIN_T = T_W'(MIN_DISTANCE);

   logic v1_ff, v2_ff, v3_ff;
   logic signed [T_W-1:0] t_near, t_far, t_sel;
   logic [30:0]  t1_in, t1_ff, t2_ff;
   logic         hit1_in, hit1_ff, hit2_ff;
   sq_pay_type   pay1_ff, pay2_ff;
   logic signed [63:0] m2_in [3];
   logic signed [63:0] m2_ff [3];
   logic signed [63:0] rnd [3];
   logic signed [34:0] ptu [3];
   logic signed [34:0] qv [3];
   logic [34:0]        qmag [3];
   div_pay_type  pay3_in, pay3_ff;
   logic [2:0][31:0] mag3_in, mag3_ff;

   always_comb begin
      t_near  = -$signed({3'b0, in_root}) - in_pay.hb;
      t_far   = $signed({3'b0, in_root}) - in_pay.hb;
      t_sel   = (t_near >= MIN_T) ? t_near : t_far;
      hit1_in = !in_pay.miss && (t_sel >= MIN_T)
              && (t_sel < $signed({8'b0, in_pay.tmax}));
      t1_in   = t_sel[30:0];

      for (int i = 0; i < 3; i++) begin
         m2_in[i] = $signed({1'b0, t1_ff}) * $signed(pay1_ff.dir[i]);
      end

      pay3_in     = '0;
      pay3_in.hit = hit2_ff;
      pay3_in.t   = t2_ff;
      for (int i = 0; i < 3; i++) begin
         rnd[i]  = m2_ff[i] + $signed(64'h2000_0000);
         ptu[i]  = $signed({{3{pay2_ff.org[i][31]}}, pay2_ff.org[i]})
                 + $signed({rnd[i][63], rnd[i][63:30]});
         qv[i]   = ptu[i] - $signed({{3{center[i][31]}}, center[i]});
         qmag[i] = qv[i][34] ? 35'(-qv[i]) : 35'(qv[i]);
         if (ptu[i][34:31] == 4'b0000 || ptu[i][34:31] == 4'b1111) begin
            pay3_in.point[i] = ptu[i][31:0];
         end else if (ptu[i][34]) begin
            pay3_in.point[i] = $signed(Q_TWO);
         end else begin
            pay3_in.point[i] = $signed(Q_MAX);
         end
         pay3_in.neg[i] = qv[i][34];
         pay3_in.big[i] = qmag[i] >= {3'b0, radius, 1'b0};
         mag3_in[i]     = qmag[i][31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      if (en) begin
         t1_ff   <= t1_in;
         hit1_ff <= hit1_in;
         pay1_ff <= in_pay;
         t2_ff   <= t1_ff;
         hit2_ff <= hit1_ff;
         pay2_ff <= pay1_ff;
         m2_ff   <= m2_in;
         pay3_ff <= pay3_in;
         mag3_ff <= mag3_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_pay   = pay3_ff;
   assign out_mag   = mag3_ff;

endmodule

### rtl/rsi_div.sv
// Normal division pipeline: one quotient bit per stage on three lanes.
module rsi_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  rsi_pkg::div_pay_type  in_pay,
   input  logic [2:0][31:0]      in_mag,
   input  logic [30:0]           radius,
   output logic                  out_valid,
   output rsi_pkg::rsp_type      out_rsp
);
   import rsi_pkg::*;

   logic             v_ff   [DIV_STEPS+1];
   logic [2:0][30:0] rem_ff [DIV_STEPS+1];
   logic [2:0][31:0] lo_ff  [DIV_STEPS+1];
   logic [2:0][31:0] quo_ff [DIV_STEPS+1];
   div_pay_type      pay_ff [DIV_STEPS+1];

   logic [62:0]      num [3];
   logic [2:0][30:0] rem0_in;
   logic [2:0][31:0] lo0_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         num[i]     = 63'({in_mag[i], 30'b0}) + 63'(radius[30:1]);
         rem0_in[i] = num[i][62:32];
         lo0_in[i]  = num[i][31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
      if (en) begin
         rem_ff[0] <= rem0_in;
         lo_ff[0]  <= lo0_in;
         quo_ff[0] <= '0;
         pay_ff[0] <= in_pay;
      end
   end

   for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
      logic [2:0][30:0] rem_in;
      logic [2:0][31:0] lo_in, quo_in;
      logic [31:0]      trial [3];

      always_comb begin
         for (int i = 0; i < 3; i++) begin
            trial[i] = {rem_ff[k-1][i], lo_ff[k-1][i][31]};
            lo_in[i] = lo_ff[k-1][i] << 1;
            if (trial[i] >= {1'b0, radius}) begin
               rem_in[i] = 31'(trial[i] - {1'b0, radius});
               quo_in[i] = {quo_ff[k-1][i][30:0], 1'b1};
            end else begin
               rem_in[i] = trial[i][30:0];
               quo_in[i] = {quo_ff[k-1][i][30:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_ff[k-1];
         end
         if (en) begin
            rem_ff[k] <= rem_in;
            lo_ff[k]  <= lo_in;
            quo_ff[k] <= quo_in;
            pay_ff[k] <= pay_ff[k-1];
         end
      end
   end

   logic        vo_ff;
   rsp_type     rsp_in, rsp_ff;
   logic [31:0] qc  [3];
   logic [31:0] nrm [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (pay_ff[DIV_STEPS].big[i] || quo_ff[DIV_STEPS][i] > Q_TWO) begin
            qc[i] = Q_TWO;
         end else begin
            qc[i] = quo_ff[DIV_STEPS][i];
         end
         if (radius == '0) begin
            nrm[i] = '0;
         end else if (pay_ff[DIV_STEPS].neg[i]) begin
            nrm[i] = -qc[i];
         end else begin
            nrm[i] = (qc[i] > Q_MAX) ? Q_MAX : qc[i];
         end
      end
      rsp_in = '0;
      if (pay_ff[DIV_STEPS].hit) begin
         rsp_in.hit_found    = 1'b1;
         rsp_in.hit_distance = pay_ff[DIV_STEPS].t;
         rsp_in.point_x      = pay_ff[DIV_STEPS].point[0];
         rsp_in.point_y      = pay_ff[DIV_STEPS].point[1];
         rsp_in.point_z      = pay_ff[DIV_STEPS].point[2];
         rsp_in.normal_x     = $signed(nrm[0]);
         rsp_in.normal_y     = $signed(nrm[1]);
         rsp_in.normal_z     = $signed(nrm[2]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (en) begin
         vo_ff <= v_ff[DIV_STEPS];
      end
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = vo_ff;
   assign out_rsp   = rsp_ff;

endmodule

### rtl/ray_sphere_intersect.sv
// Top level of the ray sphere intersection pipeline.
//
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_ready  rsi_pkg::req_type
// rsp      out        rsp_valid/rsp_ready  rsi_pkg::rsp_type
// csr      in         csr_valid/csr_ready  csr_index, csr_data
//
// One request per cycle while the pipe is not held; from accept to rsp_valid
// each request passes 5 front stages, 36 root stages, 3 tail stages, 33 quotient
// stages, the output register and the output queue write.
// Reset is synchronous: it clears all valid bits and the output queue and
// loads the sphere registers with center 0 and radius 1.0.
// A two-entry output queue holds results; when it is full and the last stage
// holds a result, the whole pipe holds and req_ready drops.
module ray_sphere_intersect (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  rsi_pkg::req_type       req,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsi_pkg::rsp_type       rsp,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  rsi_pkg::csr_index_type csr_index,
   input  logic [31:0]            csr_data
);
   import rsi_pkg::*;

   s32_type [2:0] center_in, center_ff;
   logic [30:0]   radius_in, radius_ff;

   logic        en;
   logic        f_valid, s_valid, t_valid, d_valid;
   logic [SQ_W-1:0]   f_op;
   logic [ROOT_W-1:0] s_root;
   sq_pay_type        f_pay, s_pay;
   div_pay_type       t_pay;
   logic [2:0][31:0]  t_mag;
   rsp_type           d_rsp;

   rsp_type     queue_ff [2];
   logic [0:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        push, pop;

   always_comb begin
      center_in = center_ff;
      radius_in = radius_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_CENTER_X: center_in[0] = csr_data;
            CSR_CENTER_Y: center_in[1] = csr_data;
            CSR_CENTER_Z: center_in[2] = csr_data;
            CSR_RADIUS:   radius_in    = csr_data[30:0];
         endcase
      end
   end

   assign csr_ready = 1'b1;

   assign en        = !(d_valid && cnt_ff == 2'd2);
   assign req_ready = en;
   assign push      = en && d_valid;
   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = cnt_ff != 2'd0;
   assign rsp       = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff <= '0;
         radius_ff <= 31'd65536;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         center_ff <= center_in;
         radius_ff <= radius_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) begin
         queue_ff[wr_ptr_ff] <= d_rsp;
      end
   end

   rsi_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_req    (req),
      .center    (center_ff),
      .radius    (radius_ff),
      .out_valid (f_valid),
      .out_op    (f_op),
      .out_pay   (f_pay)
   );

   rsi_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f_valid),
      .in_op     (f_op),
      .in_pay    (f_pay),
      .out_valid (s_valid),
      .out_root  (s_root),
      .out_pay   (s_pay)
   );

   rsi_tail u_tail (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s_valid),
      .in_root   (s_root),
      .in_pay    (s_pay),
      .center    (center_ff),
      .radius    (radius_ff),
      .out_valid (t_valid),
      .out_pay   (t_pay),
      .out_mag   (t_mag)
   );

   rsi_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (t_valid),
      .in_pay    (t_pay),
      .in_mag    (t_mag),
      .radius    (radius_ff),
      .out_valid (d_valid),
      .out_rsp   (d_rsp)
   );

endmodule

### rtl/ray_sphere_intersect_checker.sv
// Port-level checks of the ray sphere intersection block and their binding.
`include "assert_macros.svh"

module ray_sphere_intersect_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input rsi_pkg::rsp_type rsp
);
   import rsi_pkg::*;

   `RSI_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
   `RSI_ASSERT(a_miss_zero, rsp_valid && !rsp.hit_found |-> rsp == '0)
   `RSI_ASSERT(a_hit_min, rsp_valid && rsp.hit_found |-> rsp.hit_distance >= 31'(MIN_DISTANCE))
   `RSI_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid)

endmodule

bind ray_sphere_intersect ray_sphere_intersect_checker u_checker (.*);

### tb/sv/testbench.sv
// Self-checking testbench for the ray sphere intersection pipeline.
`timescale 1ns / 100ps

module testbench;
   import rsi_pkg::*;

   logic          clock = 0;
   logic          reset = 1;
   logic          req_valid = 0;
   logic          req_ready;
   req_type       req = '0;
   logic          rsp_valid;
   logic          rsp_ready = 0;
   rsp_type       rsp;
   logic          csr_valid = 0;
   logic          csr_ready;
   csr_index_type csr_index = CSR_CENTER_X;
   logic [31:0]   csr_data = '0;

   s32_type       sphere_cx = 0, sphere_cy = 0, sphere_cz = 0;
   logic [30:0]   sphere_r = 31'd65536;

   rsp_type       pending_hits[$];
   int            errors = 0;
   int            rays_sent = 0;
   int            rays_checked = 0;
   int            hits_seen = 0;
   int            hold_left = 0;
   bit            calm = 0;

   ray_sphere_intersect uut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 65) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic rsp_type trace_ray(req_type rq);
      longint o[3], d[3], c[3], p[3], pt;
      longint hb, t, s, dl, q, tmax;
      logic signed [131:0] disc, hw, rw, pw;
      logic [127:0] rem, sq;
      logic [63:0]  cand, sr, r, mag, quo;
      s32_type      pts[3], nrm[3];
      rsp_type      res;
      res = '0;
      r = sphere_r;
      o[0] = rq.origin_x; o[1] = rq.origin_y; o[2] = rq.origin_z;
      d[0] = rq.dir_x;    d[1] = rq.dir_y;    d[2] = rq.dir_z;
      c[0] = sphere_cx;   c[1] = sphere_cy;   c[2] = sphere_cz;
      hb = 0;
      for (int i = 0; i < 3; i++) begin
         p[i] = o[i] - c[i];
         hb += (p[i] * d[i]) >>> 30;
      end
      hw = hb;
      rw = r;
      disc = hw * hw + rw * rw;
      for (int i = 0; i < 3; i++) begin
         pw = p[i];
         disc -= pw * pw;
      end
      if (disc < 0) return res;
      rem = disc[127:0];
      sr = 0;
      for (int b = 36; b >= 0; b--) begin
         cand = sr | (64'd1 << b);
         sq = {64'd0, cand} * {64'd0, cand};
         if (sq <= rem) sr = cand;
      end
      s = sr;
      t = -s - hb;
      if (t < MIN_DISTANCE) begin
         t = s - hb;
         if (t < MIN_DISTANCE) return res;
      end
      tmax = {33'd0, rq.max_distance};
      if (t >= tmax) return res;
      res.hit_found = 1;
      res.hit_distance = t[30:0];
      for (int i = 0; i < 3; i++) begin
         dl = (t * d[i] + (64'sd1 <<< 29)) >>> 30;
         pt = o[i] + dl;
         if (pt > 64'sh7FFF_FFFF) pt = 64'sh7FFF_FFFF;
         if (pt < -64'sh8000_0000) pt = -64'sh8000_0000;
         pts[i] = pt[31:0];
         q = p[i] + dl;
         if (r == 0) begin
            nrm[i] = 0;
         end else begin
            mag = (q < 0) ? -q : q;
            if (mag >= 2 * r) quo = 64'h8000_0000;
            else quo = ((mag << 30) + r / 2) / r;
            if (quo > 64'h8000_0000) quo = 64'h8000_0000;
            if (q < 0) quo = -quo;
            else if (quo > 64'h7FFF_FFFF) quo = 64'h7FFF_FFFF;
            nrm[i] = quo[31:0];
         end
      end
      res.point_x = pts[0];  res.point_y = pts[1];  res.point_z = pts[2];
      res.normal_x = nrm[0]; res.normal_y = nrm[1]; res.normal_z = nrm[2];
      return res;
   endfunction

   function automatic void check_field(string name, longint want, longint got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endfunction

   // response checker
   always @(negedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_hits.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %h", $time, rsp);
            errors++;
         end else begin
            want = pending_hits.pop_front();
            check_field("hit_found", want.hit_found, rsp.hit_found);
            check_field("hit_distance", want.hit_distance, rsp.hit_distance);
            check_field("point_x", want.point_x, rsp.point_x);
            check_field("point_y", want.point_y, rsp.point_y);
            check_field("point_z", want.point_z, rsp.point_z);
            check_field("normal_x", want.normal_x, rsp.normal_x);
            check_field("normal_y", want.normal_y, rsp.normal_y);
            check_field("normal_z", want.normal_z, rsp.normal_z);
            rays_checked++;
            if (rsp.hit_found) hits_seen++;
         end
      end
   end

   // response receiver
   initial begin
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 0;
         end else if (stall > 0) begin
            stall--;
            rsp_ready <= 0;
         end else begin
            stall = pick_gap();
            rsp_ready <= (stall == 0);
         end
      end
   end

   task automatic send_ray(req_type rq);
      bit taken;
      req_valid <= 1;
      req <= rq;
      taken = 0;
      while (!taken) begin
         @(negedge clock);
         if (req_ready) begin
            taken = 1;
            pending_hits.push_back(trace_ray(rq));
            rays_sent++;
         end
         @(posedge clock);
      end
   endtask

   task automatic send_with_gap(req_type rq);
      int gap;
      send_ray(rq);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 0;
      while (pending_hits.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [31:0] value);
      bit taken;
      drain();
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= value;
      taken = 0;
      while (!taken) begin
         @(negedge clock);
         if (csr_ready) begin
            taken = 1;
            case (idx)
               CSR_CENTER_X: sphere_cx = value;
               CSR_CENTER_Y: sphere_cy = value;
               CSR_CENTER_Z: sphere_cz = value;
               CSR_RADIUS:   sphere_r = value[30:0];
               default: ;
            endcase
         end
         @(posedge clock);
      end
      csr_valid <= 0;
   endtask

   task automatic set_sphere(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                             logic [31:0] r);
      write_csr(CSR_CENTER_X, cx);
      write_csr(CSR_CENTER_Y, cy);
      write_csr(CSR_CENTER_Z, cz);
      write_csr(CSR_RADIUS, r);
   endtask

   function automatic req_type make_ray(s32_type ox, s32_type oy, s32_type oz,
                                        s32_type dx, s32_type dy, s32_type dz,
                                        logic [30:0] tmax);
      req_type rq;
      rq.origin_x = ox; rq.origin_y = oy; rq.origin_z = oz;
      rq.dir_x = dx;    rq.dir_y = dy;    rq.dir_z = dz;
      rq.max_distance = tmax;
      return rq;
   endfunction

   // aim a unit ray from near the sphere toward a point inside its bounding cube
   function automatic req_type aimed_ray();
      real o[3], a[3], dv[3], len, spread;
      s32_type oq[3], dq[3];
      req_type rq;
      spread = $urandom_range(1, 16);
      len = 0;
      for (int i = 0; i < 3; i++) begin
         o[i] = (($urandom_range(0, 2000) - 1000.0) / 100.0) * spread;
         a[i] = ($urandom_range(0, 2000) - 1000.0) / 1000.0 * (sphere_r / 65536.0);
      end
      o[0] += $signed(sphere_cx) / 65536.0;
      o[1] += $signed(sphere_cy) / 65536.0;
      o[2] += $signed(sphere_cz) / 65536.0;
      a[0] += $signed(sphere_cx) / 65536.0;
      a[1] += $signed(sphere_cy) / 65536.0;
      a[2] += $signed(sphere_cz) / 65536.0;
      for (int i = 0; i < 3; i++) begin
         if (o[i] > 32000.0) o[i] = 32000.0;
         if (o[i] < -32000.0) o[i] = -32000.0;
         dv[i] = a[i] - o[i];
         len += dv[i] * dv[i];
      end
      len = $sqrt(len);
      if (len < 1.0e-6) begin
         dv[0] = 1.0; len = 1.0;
      end
      for (int i = 0; i < 3; i++) begin
         oq[i] = $rtoi(o[i] * 65536.0);
         dq[i] = $rtoi(dv[i] / len * 1073741824.0);
      end
      rq = make_ray(oq[0], oq[1], oq[2], dq[0], dq[1], dq[2], 31'h7FFF_FFFF);
      if ($urandom_range(0, 3) == 0) begin
         rq.max_distance = 31'($urandom_range(0, 32'h00FF_FFFF));
      end
      return rq;
   endfunction

   function automatic req_type noise_ray();
      req_type rq;
      rq = make_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    31'($urandom));
      return rq;
   endfunction

   task automatic test_directed();
      localparam s32_type ONE = 32'sd65536;
      localparam s32_type UNIT = 32'sd1073741824;
      localparam logic [30:0] FAR = 31'h7FFF_FFFF;
      localparam logic [30:0] FOUR = 31'h0004_0000;
      calm = 1;
      // straight on, from outside
      send_ray(make_ray(-5 * ONE, 0, 0, UNIT, 0, 0, FAR));
      send_ray(make_ray(0, 5 * ONE, 0, 0, -UNIT, 0, FAR));
      send_ray(make_ray(0, 0, -3 * ONE, 0, 0, UNIT, FAR));
      // inside the sphere takes the farther root
      send_ray(make_ray(0, 0, 0, UNIT, 0, 0, FAR));
      send_ray(make_ray(ONE / 2, 0, 0, -UNIT, 0, 0, FAR));
      // pointing away: both roots behind
      send_ray(make_ray(-5 * ONE, 0, 0, -UNIT, 0, 0, FAR));
      // off to the side: negative discriminant
      send_ray(make_ray(-5 * ONE, 2 * ONE, 0, UNIT, 0, 0, FAR));
      // tangent
      send_ray(make_ray(-5 * ONE, ONE, 0, UNIT, 0, 0, FAR));
      // maximum distance cuts off the hit
      send_ray(make_ray(-5 * ONE, 0, 0, UNIT, 0, 0, 31'd0));
      send_ray(make_ray(-5 * ONE, 0, 0, UNIT, 0, 0, FOUR));
      send_ray(make_ray(-5 * ONE, 0, 0, UNIT, 0, 0, FOUR + 31'd1));
      // on the surface: nearer root below the minimum distance
      send_ray(make_ray(-ONE, 0, 0, UNIT, 0, 0, FAR));
      // extremes of every field
      send_ray(make_ray(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                        32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, FAR));
      send_ray(make_ray(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                        32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, FAR));
      send_ray(make_ray(32'sh8000_0000, 0, 0, 32'sh7FFF_FFFF, 0, 0, FAR));
      send_ray(make_ray(0, 0, 0, 0, 0, 0, FAR));
      // non-unit direction saturates the normal
      send_ray(make_ray(-5 * ONE, 0, 0, 32'sh7FFF_FFFF, 0, 0, FAR));
      send_ray(make_ray(0, 0, 0, 32'sh8000_0000, 32'sh8000_0000, 0, FAR));
      drain();
      // zero radius, and radius with the unused top bit set
      set_sphere(0, 0, 0, 0);
      send_ray(make_ray(-5 * ONE, 0, 0, UNIT, 0, 0, FAR));
      send_ray(make_ray(0, 0, 0, UNIT, 0, 0, FAR));
      set_sphere(0, 0, 0, 32'h8001_0000);
      send_ray(make_ray(-5 * ONE, 0, 0, UNIT, 0, 0, FAR));
      // hit point saturates near the range edge
      set_sphere(32'h7FFF_0000, 0, 0, 32'h7FFF_FFFF);
      send_ray(make_ray(32'sh7FF0_0000, 0, 0, UNIT, 0, 0, FAR));
      send_ray(make_ray(32'sh7FFF_0000, 0, 0, -UNIT, 0, 0, FAR));
      drain();
      calm = 0;
   endtask

   task automatic random_phase(int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 9) < 8) send_with_gap(aimed_ray());
         else send_with_gap(noise_ray());
      end
      drain();
   endtask

   task automatic test_random();
      set_sphere(0, 0, 0, 32'h0001_0000);
      random_phase(70);
      set_sphere($urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000,
                 $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000,
                 $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000,
                 $urandom_range(32'h0000_4000, 32'h0010_0000));
      random_phase(30);
      set_sphere(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      random_phase(40);
      set_sphere(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1);
      random_phase(40);
      set_sphere($urandom, $urandom, $urandom, $urandom);
      random_phase(40);
      set_sphere(32'h0003_0000, 32'hFFFE_0000, 32'h0000_8000, 32'h0005_0000);
      calm = 1;
      random_phase(40);
      calm = 0;
   endtask

   task automatic test_backpressure();
      hold_left = 300;
      calm = 1;
      for (int i = 0; i < 120; i++) send_ray(aimed_ray());
      calm = 0;
      drain();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      test_random();
      test_backpressure();
      drain();
      repeat (100) @(posedge clock);
      $display("covered %0d rays over ten sphere settings, %0d checked, %0d hits",
               rays_sent, rays_checked, hits_seen);
      $display("directed edge cases, random aimed and noise rays, a full pipe under a long output stall");
      if (errors == 0 && pending_hits.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #8ms;
      $display("simulation failed");
      $finish;
   end

endmodule

### sim.f
+incdir+rtl
rtl/rsi_pkg.sv
rtl/rsi_front.sv
rtl/rsi_sqrt.sv
rtl/rsi_tail.sv
rtl/rsi_div.sv
rtl/ray_sphere_intersect.sv
rtl/ray_sphere_intersect_checker.sv
tb/sv/testbench.sv
